>>> hdl/rdc_pkg.sv
package rdc_pkg;

	localparam int unsigned VAL_W   = 31;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned QUO_W   = 28;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned BUF_N   = 31;
	localparam int unsigned CFG_W   = 2;

	localparam logic [CFG_W-1:0] BASE_BIN = 2'd0;
	localparam logic [CFG_W-1:0] BASE_OCT = 2'd1;
	localparam logic [CFG_W-1:0] BASE_DEC = 2'd2;

	localparam logic REG_SOURCE_BASE = 1'b0;
	localparam logic REG_TARGET_BASE = 1'b1;

	localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;

	typedef struct packed {
		logic             error;
		logic [VAL_W-1:0] value;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} push_ctl_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} pop_ctl_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_DIG,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_DIG,
		B_EMIT
	} back_state_t;

	function automatic logic [QUO_W-1:0] div10(input logic [VAL_W-1:0] x);
		logic [62:0] p;
		p = {32'b0, x} * {31'b0, RECIP_10};
		return p[62:35];
	endfunction

	function automatic logic [DIGIT_W-1:0] rem10(input logic [VAL_W-1:0] x,
		input logic [QUO_W-1:0] q);
		logic [DIGIT_W-1:0] q10;
		q10 = {q[0], 3'b000} + {q[2:0], 1'b0};
		return x[DIGIT_W-1:0] - q10;
	endfunction

endpackage

>>> hdl/rdc_front.sv
module rdc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rdc_pkg::VAL_W-1:0]   number_value,
	input  logic [rdc_pkg::CFG_W-1:0]   source_base,
	output rdc_pkg::push_ctl_t          push_ctl_push,
	input  logic                        queue_full,
	output rdc_pkg::job_t               job
);
	import rdc_pkg::*;

	front_state_t       state_q, state_d;
	logic [VAL_W-1:0]   rest_q;
	logic [QUO_W-1:0]   prod_q;
	logic [VAL_W-1:0]   acc_q;
	logic [CNT_W-1:0]   shift_q;
	logic               err_q;
	logic [DIGIT_W-1:0] d;
	logic               bad;
	logic               is_dec;
	logic               accept;
	logic               push;

	assign is_dec = source_base[1];
	assign d      = rem10(rest_q, prod_q);
	assign bad    = (source_base == BASE_BIN && d >= 4'd2) ||
		(source_base == BASE_OCT && d >= 4'd8);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (start)
					state_d = (is_dec || number_value == '0) ? F_PUSH : F_MUL;
			end
			F_MUL: state_d = F_DIG;
			F_DIG: begin
				if (bad || prod_q == '0)
					state_d = F_PUSH;
				else
					state_d = F_MUL;
			end
			F_PUSH: begin
				if (!queue_full)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != F_IDLE);
		accept = (state_q == F_IDLE) && start;
		push   = (state_q == F_PUSH) && !queue_full;
	end

	assign push_ctl_push.push = push;
	assign push_ctl_push.full = queue_full;
	assign job.error = err_q;
	assign job.value = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rest_q  <= number_value;
			acc_q   <= is_dec ? number_value : '0;
			err_q   <= 1'b0;
			shift_q <= '0;
		end else if (state_q == F_MUL) begin
			prod_q <= div10(rest_q);
		end else if (state_q == F_DIG) begin
			if (bad) begin
				err_q <= 1'b1;
			end else begin
				acc_q   <= acc_q | ({{(VAL_W-DIGIT_W){1'b0}}, d} << shift_q);
				shift_q <= shift_q + ((source_base == BASE_BIN) ? 5'd1 : 5'd3);
				rest_q  <= {{(VAL_W-QUO_W){1'b0}}, prod_q};
			end
		end
	end

endmodule

>>> hdl/rdc_queue.sv
module rdc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  rdc_pkg::push_ctl_t push_ctl,
	input  rdc_pkg::job_t      wr_job,
	output logic               full,
	input  logic               pop,
	output rdc_pkg::pop_ctl_t  pop_ctl,
	output rdc_pkg::job_t      rd_job
);
	import rdc_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full          = (count_q == 2'd2);
	assign pop_ctl.empty = (count_q == 2'd0);
	assign pop_ctl.pop   = pop;
	assign do_push       = push_ctl.push && !full;
	assign do_pop        = pop && !pop_ctl.empty;
	assign rd_job        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

>>> hdl/rdc_back.sv
module rdc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rdc_pkg::CFG_W-1:0]     target_base,
	input  rdc_pkg::pop_ctl_t             pop_ctl,
	input  rdc_pkg::job_t                 job,
	output logic                          pop,
	output logic                          strobe,
	output logic [rdc_pkg::DIGIT_W-1:0]   digit,
	output logic                          last,
	output logic                          error
);
	import rdc_pkg::*;

	back_state_t        state_q, state_d;
	logic [VAL_W-1:0]   val_q;
	logic [QUO_W-1:0]   prod_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIGIT_W-1:0] buf_q [BUF_N];
	logic [DIGIT_W-1:0] d;
	logic [VAL_W-1:0]   nxt;
	logic               is_dec;
	logic               emit;
	logic               take;
	logic               strobe_q;
	logic [DIGIT_W-1:0] digit_q;
	logic               last_q;
	logic               error_q;

	assign is_dec = target_base[1];

	always_comb begin
		unique case (target_base)
			BASE_BIN: begin
				d   = {3'b000, val_q[0]};
				nxt = val_q >> 1;
			end
			BASE_OCT: begin
				d   = {1'b0, val_q[2:0]};
				nxt = val_q >> 3;
			end
			default: begin
				d   = rem10(val_q, prod_q);
				nxt = {{(VAL_W-QUO_W){1'b0}}, prod_q};
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!pop_ctl.empty && !job.error)
					state_d = is_dec ? B_MUL : B_DIG;
			end
			B_MUL: state_d = B_DIG;
			B_DIG: begin
				if (nxt == '0)
					state_d = B_EMIT;
				else
					state_d = is_dec ? B_MUL : B_DIG;
			end
			B_EMIT: begin
				if (cnt_q == 5'd1)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		take = (state_q == B_IDLE) && !pop_ctl.empty;
		emit = (state_q == B_EMIT);
		pop  = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (take && job.error) || emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			val_q <= job.value;
			cnt_q <= '0;
		end else if (state_q == B_MUL) begin
			prod_q <= div10(val_q);
		end else if (state_q == B_DIG) begin
			buf_q[cnt_q] <= d;
			cnt_q        <= cnt_q + 5'd1;
			val_q        <= nxt;
		end else if (emit) begin
			cnt_q <= cnt_q - 5'd1;
		end
		digit_q <= take ? '0 : buf_q[cnt_q - 5'd1];
		last_q  <= take ? 1'b1 : (cnt_q == 5'd1);
		error_q <= take;
	end

	assign strobe = strobe_q;
	assign digit  = digit_q;
	assign last   = last_q;
	assign error  = error_q;

endmodule

>>> hdl/radix_digit_converter.sv
// Radix digit converter.
// Input: number_value is taken at a clock edge with start high and busy low.
// Its decimal digits are read as digits in the source base (0 binary,
// 1 octal, 2 or 3 decimal) and the value is sent out as target-base digits.
// Output: one digit per strobe cycle, most significant first, last marking
// the final digit. An invalid source digit gives a single strobe with error
// and last high and digit zero. Zero gives a single 0 digit.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 source
// base, 1 target base) at once; write only while no item is in flight.
// Flow: the front end runs a reciprocal multiply, then a digit check, for
// each input digit of a binary or octal source and skips both for decimal
// ones, then pushes the value into a two-entry queue. The back end takes
// the value, makes each binary or octal digit directly or each decimal
// digit after a multiply, then emits the digits. The slower end sets the
// rate, and busy holds while the queue is full.
// Reset clears the control state; source base resets to decimal, target to
// binary. Results cannot be stalled by the receiver.
module radix_digit_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rdc_pkg::VAL_W-1:0]     number_value,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [rdc_pkg::CFG_W-1:0]     cfg_data,
	output logic                          strobe,
	output logic [rdc_pkg::DIGIT_W-1:0]   digit,
	output logic                          last,
	output logic                          error
);
	import rdc_pkg::*;

	logic [CFG_W-1:0] source_base_q;
	logic [CFG_W-1:0] target_base_q;
	push_ctl_t        push_ctl;
	pop_ctl_t         pop_ctl;
	job_t             wr_job;
	job_t             rd_job;
	logic             queue_full;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_base_q <= BASE_DEC;
			target_base_q <= BASE_BIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_BASE: source_base_q <= cfg_data;
				REG_TARGET_BASE: target_base_q <= cfg_data;
				default:         source_base_q <= source_base_q;
			endcase
		end
	end

	rdc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.number_value  (number_value),
		.source_base   (source_base_q),
		.push_ctl_push (push_ctl),
		.queue_full    (queue_full),
		.job           (wr_job)
	);

	rdc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_ctl (push_ctl),
		.wr_job   (wr_job),
		.full     (queue_full),
		.pop      (pop),
		.pop_ctl  (pop_ctl),
		.rd_job   (rd_job)
	);

	rdc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.target_base (target_base_q),
		.pop_ctl     (pop_ctl),
		.job         (rd_job),
		.pop         (pop),
		.strobe      (strobe),
		.digit       (digit),
		.last        (last),
		.error       (error)
	);

endmodule

>>> verif/radix_digit_converter_tb.sv
module radix_digit_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rdc_pkg::*;

	localparam logic [CFG_W-1:0] BASE_DEC_ALT = 2'd3;
	localparam int unsigned      STALL_LIMIT  = 2000;
	localparam int unsigned      DRAIN_CYCLES = 80;
	localparam int unsigned      PHASE_ITEMS  = 18;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
		logic               error;
	} conv_digit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [VAL_W-1:0]   number_value = '0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = REG_SOURCE_BASE;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               strobe;
	logic [DIGIT_W-1:0] digit;
	logic               last;
	logic               error;

	logic [CFG_W-1:0] src_code = BASE_DEC;
	logic [CFG_W-1:0] tgt_code = BASE_BIN;
	conv_digit_t      digits_due[$];
	int unsigned      fail_count = 0;
	int unsigned      idle_cycles = 0;
	int unsigned      pending_gap = 0;
	bit               start_held = 1'b0;
	bit               burst = 1'b0;

	radix_digit_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.number_value(number_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.digit(digit),
		.last(last),
		.error(error)
	);

	always #4 clk = ~clk;

	function automatic int unsigned radix_of(input logic [CFG_W-1:0] code);
		case (code)
			BASE_BIN: return 2;
			BASE_OCT: return 8;
			default: return 10;
		endcase
	endfunction

	function automatic void predict_digits(input logic [VAL_W-1:0] num);
		int unsigned       sb;
		int unsigned       tb;
		int unsigned       rest;
		int unsigned       d;
		longint unsigned   acc;
		longint unsigned   weight;
		logic [DIGIT_W-1:0] buf_lsf[32];
		int                n;
		conv_digit_t       r;
		sb = radix_of(src_code);
		tb = radix_of(tgt_code);
		rest = num;
		acc = 0;
		weight = 1;
		n = 0;
		while (rest != 0) begin
			d = rest % 10;
			if (d >= sb) begin
				r.digit = '0;
				r.last = 1'b1;
				r.error = 1'b1;
				digits_due.push_back(r);
				return;
			end
			acc += longint'(d) * weight;
			weight *= sb;
			rest /= 10;
		end
		do begin
			buf_lsf[n] = DIGIT_W'(acc % tb);
			n++;
			acc /= tb;
		end while (acc != 0);
		for (int k = 0; k < n; k++) begin
			r.digit = buf_lsf[n - 1 - k];
			r.last = (k == n - 1);
			r.error = 1'b0;
			digits_due.push_back(r);
		end
	endfunction

	// random digit string in the source base; some raw values, some with one bad digit
	function automatic logic [VAL_W-1:0] make_number(input int unsigned sb);
		longint unsigned acc;
		int unsigned     kind;
		int unsigned     len;
		int unsigned     bad_pos;
		int unsigned     d;
		kind = $urandom_range(0, 9);
		if (kind == 0)
			return VAL_W'($urandom);
		if (kind == 1)
			return VAL_W'($urandom_range(0, 99));
		len = $urandom_range(1, 10);
		bad_pos = (len == 10) ? $urandom_range(1, 9) : $urandom_range(0, len - 1);
		acc = 0;
		for (int i = 0; i < len; i++) begin
			if (kind == 2 && sb < 10 && i == bad_pos)
				d = $urandom_range(sb, 9);
			else if (i == 0 && len == 10)
				d = 1;
			else
				d = $urandom_range(0, sb - 1);
			acc = acc * 10 + d;
		end
		return VAL_W'(acc);
	endfunction

	task automatic send_number(input logic [VAL_W-1:0] v);
		repeat (pending_gap) @(posedge clk);
		start <= 1'b1;
		number_value <= v;
		do @(posedge clk); while (busy);
		predict_digits(v);
		if ($urandom_range(0, 7) == 0)
			burst = ~burst;
		pending_gap = burst ? 0 : $urandom_range(0, 17);
		start_held = (pending_gap == 0);
		if (!start_held)
			start <= 1'b0;
	endtask

	task automatic drain_phase();
		if (start_held)
			start <= 1'b0;
		start_held = 1'b0;
		while (digits_due.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic set_bases(input logic [CFG_W-1:0] src, input logic [CFG_W-1:0] tgt);
		cfg_we <= 1'b1;
		cfg_index <= REG_SOURCE_BASE;
		cfg_data <= src;
		@(posedge clk);
		src_code = src;
		cfg_index <= REG_TARGET_BASE;
		cfg_data <= tgt;
		@(posedge clk);
		tgt_code = tgt;
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_number(VAL_W'(0));
		send_number(VAL_W'(1));
		send_number(VAL_W'(2147483647));
		send_number(VAL_W'(1073741824));
		drain_phase();
	endtask

	task automatic test_binary_source();
		set_bases(BASE_BIN, BASE_OCT);
		send_number(VAL_W'(1111111111));
		send_number(VAL_W'(1010101010));
		send_number(VAL_W'(0));
		send_number(VAL_W'(2));
		send_number(VAL_W'(1000000009));
		drain_phase();
	endtask

	task automatic test_octal_source();
		set_bases(BASE_OCT, BASE_DEC);
		send_number(VAL_W'(1777777777));
		send_number(VAL_W'(7));
		send_number(VAL_W'(8));
		send_number(VAL_W'(76543210));
		send_number(VAL_W'(1234567));
		drain_phase();
	endtask

	task automatic test_code_three();
		set_bases(BASE_DEC_ALT, BASE_DEC_ALT);
		send_number(VAL_W'(2147483647));
		send_number(VAL_W'(999999999));
		send_number(VAL_W'(10));
		drain_phase();
		set_bases(BASE_DEC, BASE_BIN);
		send_number(VAL_W'(0));
		send_number(VAL_W'(9));
		drain_phase();
	endtask

	task automatic test_random_conversions();
		logic [CFG_W-1:0] src;
		logic [CFG_W-1:0] tgt;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin src = BASE_BIN; tgt = BASE_BIN; end
				1: begin src = BASE_DEC_ALT; tgt = BASE_DEC; end
				2: begin src = BASE_OCT; tgt = BASE_DEC_ALT; end
				3: begin src = BASE_DEC; tgt = BASE_OCT; end
				default: begin
					src = CFG_W'($urandom_range(0, 3));
					tgt = CFG_W'($urandom_range(0, 3));
				end
			endcase
			set_bases(src, tgt);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_number(make_number(radix_of(src_code)));
			drain_phase();
		end
	endtask

	always @(posedge clk) begin
		conv_digit_t want;
		if (arst_n && strobe) begin
			if (digits_due.size() == 0) begin
				$display("%0t: unexpected digit %0d last %0d error %0d", $time, digit, last, error);
				fail_count++;
			end else begin
				want = digits_due.pop_front();
				if (digit !== want.digit || last !== want.last || error !== want.error) begin
					$display("%0t: expected digit %0d last %0d error %0d, got %0d %0d %0d",
						$time, want.digit, want.last, want.error, digit, last, error);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		pending_gap = $urandom_range(0, 17);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_binary_source();
		test_octal_source();
		test_code_three();
		test_random_conversions();
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (digits_due.size() != 0) begin
			conv_digit_t left;
			left = digits_due.pop_front();
			$display("%0t: expected digit %0d last %0d error %0d, got nothing",
				$time, left.digit, left.last, left.error);
			fail_count++;
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
